[design/mm64_pkg.sv]
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared types, constants and helpers for the MurmurHash64A stream hasher.
// ----------------------------------------------------------------------------
package mm64_pkg;

   // Mixing constants
   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   // Multiplier pipeline latency, in cycles from operand load to product
   localparam int unsigned MUL_LATENCY = 2;

   // Item queue between front and core
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register file: one 64-bit register at byte address 8*i
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic        REG_SEED   = 1'b0;

   // What an item asks the core to do
   typedef enum logic [1:0] {
      KIND_FULL,   // eight bytes, full mix
      KIND_TAIL,   // one to seven bytes, xor and multiply
      KIND_NONE    // no bytes, finalize only
   } kind_type;

   // Classified item as it travels through the queue
   typedef struct packed {
      logic [63:0] word;
      kind_type    kind;
      logic        first;
      logic        done;
      logic [31:0] length;
   } entry_type;

   // Core sequencer states
   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_SEED,
      CORE_KEY1,
      CORE_KEY2,
      CORE_MIXH,
      CORE_FINAL
   } core_state_type;

   // Shift-xor step used by key mixing and finalization
   function automatic logic [63:0] shift_xor(input logic [63:0] x);
      shift_xor = x ^ (x >> MIX_SHIFT);
   endfunction

endpackage

[design/mm64_front.sv]
// ----------------------------------------------------------------------------
// mm64_front
// Accepts items, saturates the byte count, masks tail bytes and tags each
// item with its kind and whether it opens or closes a message.
// ----------------------------------------------------------------------------
module mm64_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [63:0]         req_data_word,
   input  logic [3:0]          req_byte_count,
   input  logic                req_last_word,
   input  logic [31:0]         req_message_length,
   input  logic                q_full,
   output logic                q_write,
   output mm64_pkg::entry_type q_entry
);

   logic       in_msg_ff;
   logic       in_msg_in;
   logic [3:0] count_sat;
   logic [63:0] word_masked;

   // Saturate the count and drop bytes beyond it
   always_comb begin
      count_sat = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      for (int b = 0; b < 8; b++) begin
         word_masked[b*8 +: 8] = (4'(b) < count_sat) ? req_data_word[b*8 +: 8] : 8'h00;
      end
   end

   // Classify the item
   always_comb begin
      q_entry.word   = word_masked;
      q_entry.length = req_message_length;
      q_entry.first  = ~in_msg_ff;
      if (count_sat == 4'd8) begin
         q_entry.kind = mm64_pkg::KIND_FULL;
         q_entry.done = req_last_word;
      end else if (count_sat == 4'd0) begin
         q_entry.kind = mm64_pkg::KIND_NONE;
         q_entry.done = 1'b1;
      end else begin
         q_entry.kind = mm64_pkg::KIND_TAIL;
         q_entry.done = 1'b1;
      end
   end

   assign q_write   = req_push & ~q_full;
   assign in_msg_in = q_write ? ~q_entry.done : in_msg_ff;

   // Track message boundaries
   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

[design/mm64_queue.sv]
// ----------------------------------------------------------------------------
// mm64_queue
// Short item queue that decouples the front from the core.
// ----------------------------------------------------------------------------
module mm64_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  mm64_pkg::entry_type wr_entry,
   output logic                full,
   input  logic                rd_en,
   output logic                rd_valid,
   output mm64_pkg::entry_type rd_entry
);

   mm64_pkg::entry_type                  slot_ff [mm64_pkg::QUEUE_DEPTH];
   logic [mm64_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [mm64_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [mm64_pkg::QCNT_W-1:0]          count_ff,  count_in;

   assign full     = (count_ff == mm64_pkg::QCNT_W'(mm64_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == mm64_pkg::QPTR_W'(mm64_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == mm64_pkg::QPTR_W'(mm64_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store item payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

[design/mm64_mul.sv]
// ----------------------------------------------------------------------------
// mm64_mul
// Two-stage multiplier by the mixing constant, low 64 bits of the product.
// Stage one forms the low partial product, stage two adds the cross terms.
// ----------------------------------------------------------------------------
module mm64_mul (
   input  logic        clock,
   input  logic [63:0] operand,
   output logic [63:0] product
);

   localparam logic [31:0] MUL_LO = mm64_pkg::MIX_MUL[31:0];
   localparam logic [31:0] MUL_HI = mm64_pkg::MIX_MUL[63:32];

   logic [63:0] lo_prod_ff, lo_prod_in;
   logic [31:0] a_lo_ff, a_hi_ff;
   logic [31:0] cross_sum;
   logic [63:0] product_ff, product_in;

   // Low partial product
   assign lo_prod_in = 64'(operand[31:0]) * 64'(MUL_LO);

   // Cross terms land in the upper half only
   assign cross_sum  = (a_hi_ff * MUL_LO) + (a_lo_ff * MUL_HI);
   assign product_in = lo_prod_ff + {cross_sum, 32'h0};

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      a_lo_ff    <= operand[31:0];
      a_hi_ff    <= operand[63:32];
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[design/mm64_core.sv]
// ----------------------------------------------------------------------------
// mm64_core
// Sequencer that takes classified items from the queue and runs the seed,
// key mix, hash mix and finalization steps through one shared multiplier.
// ----------------------------------------------------------------------------
module mm64_core (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         seed,
   input  logic                q_valid,
   input  mm64_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                out_valid,
   output logic [63:0]         out_hash,
   input  logic                out_pop
);

   mm64_pkg::core_state_type state_ff, state_in;
   logic [63:0]        h_ff, h_in;
   logic [63:0]        word_ff, word_in;
   mm64_pkg::kind_type kind_ff, kind_in;
   logic               done_ff, done_in;
   logic [63:0]        mul_a_ff, mul_a_in;
   logic [1:0]         wait_ff, wait_in;
   logic               out_valid_ff, out_valid_in;
   logic [63:0]        out_hash_ff, out_hash_in;
   logic [63:0]        mul_p;
   logic               prod_ready;
   logic               disp_go;
   mm64_pkg::kind_type disp_kind;
   logic [63:0]        disp_word;
   logic [63:0]        disp_h;

   mm64_mul u_mul (
      .clock   (clock),
      .operand (mul_a_ff),
      .product (mul_p)
   );

   assign prod_ready = (wait_ff == 2'd0);

   // Sequence the multiply steps
   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      word_in      = word_ff;
      kind_in      = kind_ff;
      done_in      = done_ff;
      mul_a_in     = mul_a_ff;
      wait_in      = prod_ready ? 2'd0 : wait_ff - 2'd1;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff & ~out_pop;
      out_hash_in  = out_hash_ff;
      disp_go      = 1'b0;
      disp_kind    = kind_ff;
      disp_word    = word_ff;
      disp_h       = h_ff;

      case (state_ff)
         mm64_pkg::CORE_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               word_in = q_entry.word;
               kind_in = q_entry.kind;
               done_in = q_entry.done;
               if (q_entry.first) begin
                  mul_a_in = 64'(q_entry.length);
                  wait_in  = 2'(mm64_pkg::MUL_LATENCY);
                  state_in = mm64_pkg::CORE_SEED;
               end else begin
                  disp_go   = 1'b1;
                  disp_kind = q_entry.kind;
                  disp_word = q_entry.word;
               end
            end
         end
         mm64_pkg::CORE_SEED: begin
            if (prod_ready) begin
               disp_go = 1'b1;
               disp_h  = seed ^ mul_p;
            end
         end
         mm64_pkg::CORE_KEY1: begin
            if (prod_ready) begin
               mul_a_in = mm64_pkg::shift_xor(mul_p);
               wait_in  = 2'(mm64_pkg::MUL_LATENCY);
               state_in = mm64_pkg::CORE_KEY2;
            end
         end
         mm64_pkg::CORE_KEY2: begin
            if (prod_ready) begin
               mul_a_in = h_ff ^ mul_p;
               wait_in  = 2'(mm64_pkg::MUL_LATENCY);
               state_in = mm64_pkg::CORE_MIXH;
            end
         end
         mm64_pkg::CORE_MIXH: begin
            if (prod_ready) begin
               if (done_ff) begin
                  mul_a_in = mm64_pkg::shift_xor(mul_p);
                  wait_in  = 2'(mm64_pkg::MUL_LATENCY);
                  state_in = mm64_pkg::CORE_FINAL;
               end else begin
                  h_in     = mul_p;
                  state_in = mm64_pkg::CORE_IDLE;
               end
            end
         end
         mm64_pkg::CORE_FINAL: begin
            // hold the hash until the output slot frees up
            if (prod_ready && (!out_valid_ff || out_pop)) begin
               out_valid_in = 1'b1;
               out_hash_in  = mm64_pkg::shift_xor(mul_p);
               state_in     = mm64_pkg::CORE_IDLE;
            end
         end
         default: begin
            state_in = mm64_pkg::CORE_IDLE;
         end
      endcase

      // Start the first step of an item once its starting hash is known
      if (disp_go) begin
         h_in    = disp_h;
         wait_in = 2'(mm64_pkg::MUL_LATENCY);
         case (disp_kind)
            mm64_pkg::KIND_FULL: begin
               mul_a_in = disp_word;
               state_in = mm64_pkg::CORE_KEY1;
            end
            mm64_pkg::KIND_TAIL: begin
               mul_a_in = disp_h ^ disp_word;
               state_in = mm64_pkg::CORE_MIXH;
            end
            mm64_pkg::KIND_NONE: begin
               mul_a_in = mm64_pkg::shift_xor(disp_h);
               state_in = mm64_pkg::CORE_FINAL;
            end
            default: begin
               state_in = mm64_pkg::CORE_IDLE;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm64_pkg::CORE_IDLE;
         wait_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      word_ff     <= word_in;
      kind_ff     <= kind_in;
      done_ff     <= done_in;
      mul_a_ff    <= mul_a_in;
      out_hash_ff <= out_hash_in;
   end

   assign out_valid = out_valid_ff;
   assign out_hash  = out_hash_ff;

endmodule

[design/murmur64a_stream_hash.sv]
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// Streaming 64-bit MurmurHash64A over little-endian words, with a seed
// register on an APB-style port.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake           Payload
//   req      in         req_push/req_full   data_word, byte_count, last_word,
//                                           message_length
//   rsp      out        rsp_pop/rsp_empty   hash_value
//   csr      in/out     psel/penable/pready seed at byte address 0
//
// A body word runs through the key mix and the hash mix; the first item of a
// message adds the seed multiply and the last item adds finalization. Each
// multiply goes through one shared two-stage multiplier (up to 5 steps per
// item).
// Reset is synchronous and clears the queue, sequencer and output slot; the
// seed returns to zero. A two-entry queue keeps accepting items while the
// core works, and the core holds a finished hash until rsp_pop takes it.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [63:0]                     req_data_word,
   input  logic [3:0]                      req_byte_count,
   input  logic                            req_last_word,
   input  logic [31:0]                     req_message_length,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [63:0]                     rsp_hash_value,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mm64_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [63:0]         seed_ff, seed_in;
   logic                csr_write;
   logic                q_write;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   mm64_pkg::entry_type front_entry;
   mm64_pkg::entry_type head_entry;
   logic                out_valid;

   // Register access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign seed_in    = (csr_write && csr_paddr[3] == mm64_pkg::REG_SEED) ?
                       csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr[3] == mm64_pkg::REG_SEED) ? seed_ff : 64'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'h0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .q_full             (q_full),
      .q_write            (q_write),
      .q_entry            (front_entry)
   );

   mm64_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_write),
      .wr_entry (front_entry),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_entry (head_entry)
   );

   mm64_core u_core (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .q_valid   (q_valid),
      .q_entry   (head_entry),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_hash  (rsp_hash_value),
      .out_pop   (rsp_pop)
   );

   assign req_full  = q_full;
   assign rsp_empty = ~out_valid;

endmodule

[design/mm64_checker.sv]
// ----------------------------------------------------------------------------
// mm64_checker
// Port-level checks for the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module mm64_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_push,
   input logic                            req_full,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input logic [63:0]                     rsp_hash_value,
   input logic                            csr_pready
);

   // Reset leaves both sides idle: no result, room for items
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue or result slot not cleared by reset");

   // Register port never stalls
   a_pready: assert property (@(posedge clock)
      disable iff (reset) csr_pready)
      else $error("csr_pready dropped");

   // Hold a waiting result until it is taken
   a_rsp_hold: assert property (@(posedge clock)
      disable iff (reset) (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hash_value)))
      else $error("waiting result changed or vanished");

   // Full only rises after an item was pushed
   a_full_cause: assert property (@(posedge clock)
      disable iff (reset) $rose(req_full) |-> $past(req_push))
      else $error("req_full rose without a push");

endmodule

bind murmur64a_stream_hash mm64_checker u_mm64_checker (.*);

[tb/murmur64a_stream_hash_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur64a_stream_hash_tb
// Self-checking bench for the streaming MurmurHash64A hasher. A short table of
// directed items covers empty messages, tails, saturated byte counts and
// ignored length fields. Random messages with occasional noise items follow,
// under three seeds and three idle patterns on the push and pop sides. Every
// popped hash is checked against a local model of the running hash, or against
// the hand-derived hash of a pinned row.
module murmur64a_stream_hash_tb;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS = 276;
   localparam int unsigned NUM_ROWS = 18;
   localparam int unsigned MAX_PRINTS = 60;
   localparam logic [mm64_pkg::CSR_ADDR_W-1:0] SEED_ADDR =
      mm64_pkg::CSR_ADDR_W'(8 * mm64_pkg::REG_SEED);

   // One row of the directed table; pinned rows carry a hand-derived hash
   typedef struct {
      logic [63:0] word;
      logic [3:0]  count;
      logic        last;
      logic [31:0] len;
      bit          pinned;
      logic [63:0] hash;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [63:0]                     req_data_word = '0;
   logic [3:0]                      req_byte_count = '0;
   logic                            req_last_word = 1'b0;
   logic [31:0]                     req_message_length = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [63:0]                     rsp_hash_value;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [mm64_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]                     csr_pwdata = '0;
   logic [63:0]                     csr_prdata;
   logic                            csr_pready;

   // Hasher model state
   logic [63:0] seed_shadow = '0;
   logic [63:0] run_hash = '0;
   bit          mid_msg = 1'b0;
   logic [63:0] hash_due[$];

   int unsigned  send_idle_pct = 0;
   int unsigned  pop_idle_pct = 0;
   int unsigned  sent_items = 0;
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   stim_row_type dir_rows[NUM_ROWS];

   murmur64a_stream_hash uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_hash_value     (rsp_hash_value),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Finalization: shift-xor, multiply, shift-xor
   function automatic logic [63:0] fold_hash(input logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> mm64_pkg::MIX_SHIFT);
      x = x * mm64_pkg::MIX_MUL;
      return x ^ (x >> mm64_pkg::MIX_SHIFT);
   endfunction

   // Advance the running hash by one item; return 1 when the message ends
   function automatic bit absorb_item(input logic [63:0] word, input logic [3:0] count,
                                      input logic last, input logic [31:0] len,
                                      output logic [63:0] hash_out);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      int unsigned n;
      bit          done;
      n = (count > 4'd8) ? 8 : int'(count);
      h = mid_msg ? run_hash : (seed_shadow ^ (64'(len) * mm64_pkg::MIX_MUL));
      hash_out = '0;
      if (n == 8) begin
         k = word * mm64_pkg::MIX_MUL;
         k = k ^ (k >> mm64_pkg::MIX_SHIFT);
         k = k * mm64_pkg::MIX_MUL;
         h = (h ^ k) * mm64_pkg::MIX_MUL;
         done = last;
      end else if (n > 0) begin
         mask = (64'd1 << (8 * n)) - 64'd1;
         h = (h ^ (word & mask)) * mm64_pkg::MIX_MUL;
         done = 1'b1;
      end else begin
         done = 1'b1;
      end
      if (done) begin
         hash_out = fold_hash(h);
         run_hash = '0;
         mid_msg = 1'b0;
      end else begin
         run_hash = h;
         mid_msg = 1'b1;
      end
      return done;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("%0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Push one item; entered and left at a falling edge
   task automatic send_item(input logic [63:0] word, input logic [3:0] count,
                            input logic last, input logic [31:0] len,
                            input bit pinned, input logic [63:0] pinned_hash);
      logic [63:0] h;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_data_word = word;
      req_byte_count = count;
      req_last_word = last;
      req_message_length = len;
      req_push = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (absorb_item(word, count, last, len, h))
         hash_due = {hash_due, (pinned ? pinned_hash : h)};
      sent_items++;
      @(negedge clock);
   endtask

   // Hold the push side until every outstanding hash has been popped
   task automatic hold_until_drained();
      req_push = 1'b0;
      while (hash_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = SEED_ADDR;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      seed_shadow = value;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // One random message, mostly well formed, sometimes a lone noise item
   task automatic send_message();
      int unsigned nbody;
      int unsigned tail;
      logic [31:0] len;
      logic [3:0]  cnt;
      int unsigned i;
      if ($urandom_range(99) < 12) begin
         send_item(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)), $urandom,
                   0, '0);
      end else begin
         nbody = ($urandom_range(9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
         tail = $urandom_range(7);
         len = 32'(8 * nbody + tail);
         if ($urandom_range(9) == 0)
            len = $urandom;
         for (i = 0; i < nbody; i++) begin
            cnt = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            if (i + 1 == nbody && tail == 0 && $urandom_range(9) < 7)
               send_item(rand64(), cnt, 1'b1, (i == 0) ? len : $urandom, 0, '0);
            else
               send_item(rand64(), cnt, 1'b0, (i == 0) ? len : $urandom, 0, '0);
         end
         // close with a tail, or a zero-byte item if the body left it open or was empty
         if (tail != 0)
            send_item(rand64(), 4'(tail), 1'($urandom_range(4) != 0),
                      (nbody == 0) ? len : $urandom, 0, '0);
         else if (mid_msg || nbody == 0)
            send_item(rand64(), 4'd0, 1'($urandom_range(1)),
                      (nbody == 0) ? len : $urandom, 0, '0);
      end
   endtask

   // Drain, let the core settle, then reprogram the seed
   task automatic quiesce_and_seed(input logic [63:0] value);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_seed(value);
   endtask

   task automatic run_phase(input logic [63:0] seed_value, input int unsigned send_pct,
                            input int unsigned pop_pct);
      int unsigned start;
      int unsigned msgs;
      quiesce_and_seed(seed_value);
      send_idle_pct = send_pct;
      pop_idle_pct = pop_pct;
      start = sent_items;
      msgs = 0;
      while (sent_items - start < PHASE_ITEMS) begin
         if (msgs == 10 || $urandom_range(99) < 3)
            hold_until_drained();
         send_message();
         msgs++;
      end
      // end the phase on a message boundary
      if (mid_msg)
         send_item(rand64(), 4'd0, 1'b1, $urandom, 0, '0);
   endtask

   // Pop side: stall at random, sample at the rising edge
   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (hash_due.size() == 0)
            report_mismatch("hash with nothing pending", rsp_hash_value, '0);
         else if (rsp_hash_value !== hash_due[0])
            report_mismatch("hash_value", rsp_hash_value, hash_due.pop_front());
         else
            void'(hash_due.pop_front());
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("murmur64a_stream_hash regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      // seed is zero for the table, so an empty length-zero message hashes to 0
      dir_rows[0]  = '{64'h0, 4'd0, 1'b1, 32'd0, 1'b1, 64'h0};
      dir_rows[1]  = '{64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 32'd0, 1'b1, 64'h0};
      dir_rows[2]  = '{64'hffff_ffff_ffff_0000, 4'd3, 1'b1, 32'd0, 1'b0, '0};
      dir_rows[3]  = '{64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 32'hffff_ffff, 1'b0, '0};
      dir_rows[4]  = '{64'hffff_ffff_ffff_ffff, 4'd1, 1'b1, 32'd1, 1'b0, '0};
      dir_rows[5]  = '{64'hffff_ffff_ffff_ffff, 4'd7, 1'b0, 32'd7, 1'b0, '0};
      dir_rows[6]  = '{64'h0, 4'd8, 1'b0, 32'd16, 1'b0, '0};
      dir_rows[7]  = '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 32'h0, 1'b0, '0};
      dir_rows[8]  = '{64'h0123_4567_89ab_cdef, 4'd15, 1'b0, 32'd9, 1'b0, '0};
      dir_rows[9]  = '{64'hfedc_ba98_7654_3210, 4'd1, 1'b1, 32'hffff_ffff, 1'b0, '0};
      dir_rows[10] = '{64'h8000_0000_0000_0001, 4'd9, 1'b0, 32'd8, 1'b0, '0};
      dir_rows[11] = '{64'hdead_beef_dead_beef, 4'd0, 1'b0, 32'd0, 1'b0, '0};
      dir_rows[12] = '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 32'h0, 1'b0, '0};
      dir_rows[13] = '{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0, 32'hffff_ffff, 1'b0, '0};
      dir_rows[14] = '{64'hffff_ffff_ffff_ffff, 4'd4, 1'b1, 32'h1234_5678, 1'b0, '0};
      dir_rows[15] = '{64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 32'd8, 1'b0, '0};
      dir_rows[16] = '{64'h7fff_ffff_ffff_fffe, 4'd2, 1'b0, 32'd2, 1'b0, '0};
      dir_rows[17] = '{64'hc3c3_c3c3_c3c3_c3c3, 4'd6, 1'b1, 32'hffff_ffff, 1'b0, '0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_seed(64'h0);

      // directed table
      send_idle_pct = 19;
      pop_idle_pct = 51;
      for (r = 0; r < NUM_ROWS; r++)
         send_item(dir_rows[r].word, dir_rows[r].count, dir_rows[r].last, dir_rows[r].len,
                   dir_rows[r].pinned, dir_rows[r].hash);

      // random messages under three seeds and idle patterns
      run_phase(64'hffff_ffff_ffff_ffff, 19, 51);
      run_phase(rand64(), 51, 19);
      run_phase(rand64(), 0, 0);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("murmur64a_stream_hash regression: pass");
      else
         $display("murmur64a_stream_hash regression: fail");
      $finish;
   end

endmodule
